[hdl/cps_pkg.sv]
package cps_pkg;

   localparam int MAX_PROC = 16;
   localparam int SLOT_W   = 4;
   localparam int CNT_W    = 5;
   localparam int PLAN_ENT = 16;
   localparam int PLAN_W   = 4;

   typedef enum logic [1:0] {
      REQ_SCHED  = 2'd0,
      REQ_CREATE = 2'd1,
      REQ_TERM   = 2'd2,
      REQ_PLAN   = 2'd3
   } req_kind_type;

   localparam logic [1:0] ST_TERMINATED = 2'd0;
   localparam logic [1:0] ST_NEW        = 2'd1;
   localparam logic [1:0] ST_READY      = 2'd2;

   localparam logic [1:0] LVL_PERIODIC = 2'd0;
   localparam logic [1:0] LVL_SPORADIC = 2'd1;
   localparam logic [1:0] LVL_DEVICE   = 2'd2;
   localparam logic [1:0] LVL_INVALID  = 2'd3;

   localparam logic [1:0] RES_OK       = 2'd0;
   localparam logic [1:0] RES_NO_SLOT  = 2'd1;
   localparam logic [1:0] RES_NOTFOUND = 2'd2;
   localparam logic [1:0] RES_BAD_LVL  = 2'd3;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_DEV_STEP,
      OP_IDLE_PICK,
      OP_IDX_CLR,
      OP_NAME_STEP,
      OP_ARM,
      OP_MOD_SUB,
      OP_POS_SET,
      OP_PROMOTE,
      OP_CRT_STEP,
      OP_CRT_COMMIT,
      OP_TRM_CLEAR,
      OP_TRM_STEP,
      OP_PLAN_WR,
      OP_EMIT
   } op_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DISPATCH,
      S_DEV,
      S_PLAN,
      S_SEARCH,
      S_ARM,
      S_MOD,
      S_PROMOTE,
      S_CRT_SCAN,
      S_CRT_COMMIT,
      S_TRM_WALK,
      S_DONE
   } state_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      req_kind_type typ;
      logic         lvl_bad;
      logic         cur_idle;
      logic         walk_end;
      logic         slot_end;
      logic         dev_due;
      logic         hit;
      logic         idle_mark;
      logic         mod_ge;
      logic         trm_match;
      logic         rsp_busy;
   } stat_type;

endpackage

[hdl/cps_ctrl.sv]
module cps_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  cps_pkg::stat_type stat,
   output cps_pkg::cmd_type  cmd
);

   cps_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cps_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd.op     = cps_pkg::OP_NONE;
      req_tready = 1'b0;
      case (state_ff)
         cps_pkg::S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.op   = cps_pkg::OP_LOAD;
               state_in = cps_pkg::S_DISPATCH;
            end
         end
         cps_pkg::S_DISPATCH: begin
            case (stat.typ)
               cps_pkg::REQ_SCHED: state_in = cps_pkg::S_DEV;
               cps_pkg::REQ_CREATE: begin
                  state_in = stat.lvl_bad ? cps_pkg::S_DONE : cps_pkg::S_CRT_SCAN;
               end
               cps_pkg::REQ_TERM: begin
                  if (stat.cur_idle) begin
                     state_in = cps_pkg::S_DONE;
                  end else begin
                     cmd.op   = cps_pkg::OP_TRM_CLEAR;
                     state_in = cps_pkg::S_TRM_WALK;
                  end
               end
               default: begin
                  cmd.op   = cps_pkg::OP_PLAN_WR;
                  state_in = cps_pkg::S_DONE;
               end
            endcase
         end
         cps_pkg::S_DEV: begin
            if (stat.walk_end) begin
               state_in = cps_pkg::S_PLAN;
            end else begin
               cmd.op = cps_pkg::OP_DEV_STEP;
               if (stat.dev_due) begin
                  state_in = cps_pkg::S_PROMOTE;
               end
            end
         end
         cps_pkg::S_PLAN: begin
            if (stat.idle_mark) begin
               cmd.op   = cps_pkg::OP_IDLE_PICK;
               state_in = cps_pkg::S_ARM;
            end else begin
               cmd.op   = cps_pkg::OP_IDX_CLR;
               state_in = cps_pkg::S_SEARCH;
            end
         end
         cps_pkg::S_SEARCH: begin
            if (stat.slot_end || stat.hit) begin
               state_in = cps_pkg::S_ARM;
            end else begin
               cmd.op = cps_pkg::OP_NAME_STEP;
            end
         end
         cps_pkg::S_ARM: begin
            cmd.op   = cps_pkg::OP_ARM;
            state_in = cps_pkg::S_MOD;
         end
         cps_pkg::S_MOD: begin
            if (stat.mod_ge) begin
               cmd.op = cps_pkg::OP_MOD_SUB;
            end else begin
               cmd.op   = cps_pkg::OP_POS_SET;
               state_in = cps_pkg::S_PROMOTE;
            end
         end
         cps_pkg::S_PROMOTE: begin
            cmd.op   = cps_pkg::OP_PROMOTE;
            state_in = cps_pkg::S_DONE;
         end
         cps_pkg::S_CRT_SCAN: begin
            if (stat.slot_end) begin
               state_in = cps_pkg::S_CRT_COMMIT;
            end else begin
               cmd.op = cps_pkg::OP_CRT_STEP;
            end
         end
         cps_pkg::S_CRT_COMMIT: begin
            cmd.op   = cps_pkg::OP_CRT_COMMIT;
            state_in = cps_pkg::S_DONE;
         end
         cps_pkg::S_TRM_WALK: begin
            if (stat.walk_end) begin
               state_in = cps_pkg::S_DONE;
            end else begin
               cmd.op = cps_pkg::OP_TRM_STEP;
               if (stat.trm_match) begin
                  state_in = cps_pkg::S_DONE;
               end
            end
         end
         cps_pkg::S_DONE: begin
            if (!stat.rsp_busy) begin
               cmd.op   = cps_pkg::OP_EMIT;
               state_in = cps_pkg::S_IDLE;
            end
         end
         default: state_in = cps_pkg::S_IDLE;
      endcase
   end

endmodule

[hdl/cps_dp.sv]
module cps_dp (
   input  logic              clock,
   input  logic              reset,
   input  logic [1:0]        req_tuser,
   input  logic [55:0]       req_tdata,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [31:0]       rsp_tdata,
   input  logic              csr_wen,
   input  logic [4:0]        csr_wdata,
   input  cps_pkg::cmd_type  cmd,
   output cps_pkg::stat_type stat
);

   localparam int SW = cps_pkg::SLOT_W;
   localparam int CW = cps_pkg::CNT_W;
   localparam int PW = cps_pkg::PLAN_W;
   localparam int NP = cps_pkg::MAX_PROC;
   localparam int NE = cps_pkg::PLAN_ENT;

   // slot table
   logic [1:0]  slot_st_ff   [NP], slot_st_in   [NP];
   logic [1:0]  slot_lvl_ff  [NP], slot_lvl_in  [NP];
   logic [15:0] slot_name_ff [NP], slot_name_in [NP];
   logic        slot_nv_ff   [NP], slot_nv_in   [NP];
   logic [15:0] slot_per_ff  [NP], slot_per_in  [NP];
   logic [15:0] slot_cd_ff   [NP], slot_cd_in   [NP];
   // rings
   logic [SW-1:0] dev_ring_ff [NP], dev_ring_in [NP];
   logic [SW-1:0] spo_ring_ff [NP], spo_ring_in [NP];
   logic [SW-1:0] dev_head_ff, dev_head_in, dev_tail_ff, dev_tail_in;
   logic [SW-1:0] spo_head_ff, spo_head_in, spo_tail_ff, spo_tail_in;
   logic [CW-1:0] dev_cnt_ff, dev_cnt_in, spo_cnt_ff, spo_cnt_in;
   // plan
   logic [15:0] plan_nm_ff [NE], plan_nm_in [NE];
   logic        plan_idl_ff [NE], plan_idl_in [NE];
   logic [15:0] plan_sl_ff [NE], plan_sl_in [NE];
   logic [PW-1:0] pos_ff, pos_in;
   logic [4:0]    plen_ff, plen_in;
   logic [PW:0]   nxt_ff, nxt_in;
   logic [4:0]    cur_ff, cur_in;
   // per transaction
   cps_pkg::req_kind_type typ_ff, typ_in;
   logic [1:0]    lvl_ff, lvl_in;
   logic [15:0]   nop_ff, nop_in;
   logic [PW-1:0] widx_ff, widx_in;
   logic          widl_ff, widl_in;
   logic [15:0]   wnm_ff, wnm_in, wsl_ff, wsl_in;
   logic [15:0]   t_ff, t_in, enm_ff, enm_in;
   logic          imark_ff, imark_in;
   logic [CW-1:0] idx_ff, idx_in, walk_n_ff, walk_n_in;
   logic          hit_ff, hit_in, taken_ff, taken_in, free_ff, free_in;
   logic [SW-1:0] free_idx_ff, free_idx_in;
   // result and output register
   logic [1:0]  res_st_ff, res_st_in;
   logic [4:0]  res_pid_ff, res_pid_in;
   logic        res_dev_ff, res_dev_in, res_arm_ff, res_arm_in, res_run_ff, res_run_in;
   logic [15:0] res_sl_ff, res_sl_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_data_ff, rsp_data_in;

   logic [SW-1:0] sidx, e_dev, e_spo, cur_slot, trm_e;
   logic [4:0]    cur_m1, used_len;
   logic [15:0]   key;
   logic          name_hit, dev_due;

   always_comb begin
      sidx     = idx_ff[SW-1:0];
      e_dev    = dev_ring_ff[dev_head_ff];
      e_spo    = spo_ring_ff[spo_head_ff];
      cur_m1   = cur_ff - 5'd1;
      cur_slot = cur_m1[SW-1:0];
      key      = (typ_ff == cps_pkg::REQ_SCHED) ? enm_ff : nop_ff;
      name_hit = slot_nv_ff[sidx] && (slot_name_ff[sidx] == key);
      dev_due  = (slot_cd_ff[e_dev] == 16'd0);
      trm_e    = (lvl_ff == cps_pkg::LVL_SPORADIC) ? e_spo : e_dev;
      if (plen_ff == 5'd0) begin
         used_len = 5'd1;
      end else if (plen_ff > 5'(NE)) begin
         used_len = 5'(NE);
      end else begin
         used_len = plen_ff;
      end
   end

   always_comb begin
      stat.typ       = typ_ff;
      stat.lvl_bad   = (lvl_ff == cps_pkg::LVL_INVALID);
      stat.cur_idle  = (cur_ff == 5'd0);
      stat.walk_end  = (idx_ff == walk_n_ff);
      stat.slot_end  = (idx_ff == CW'(NP));
      stat.dev_due   = dev_due;
      stat.hit       = hit_ff;
      stat.idle_mark = imark_ff;
      stat.mod_ge    = (nxt_ff >= used_len);
      stat.trm_match = (trm_e == cur_slot);
      stat.rsp_busy  = rsp_valid_ff && !rsp_tready;
   end

   always_comb begin
      slot_st_in = slot_st_ff;  slot_lvl_in = slot_lvl_ff; slot_name_in = slot_name_ff;
      slot_nv_in = slot_nv_ff;  slot_per_in = slot_per_ff; slot_cd_in = slot_cd_ff;
      dev_ring_in = dev_ring_ff; spo_ring_in = spo_ring_ff;
      dev_head_in = dev_head_ff; dev_tail_in = dev_tail_ff; dev_cnt_in = dev_cnt_ff;
      spo_head_in = spo_head_ff; spo_tail_in = spo_tail_ff; spo_cnt_in = spo_cnt_ff;
      plan_nm_in = plan_nm_ff; plan_idl_in = plan_idl_ff; plan_sl_in = plan_sl_ff;
      pos_in = pos_ff; nxt_in = nxt_ff; cur_in = cur_ff;
      plen_in = csr_wen ? csr_wdata : plen_ff;
      typ_in = typ_ff; lvl_in = lvl_ff; nop_in = nop_ff; widx_in = widx_ff;
      widl_in = widl_ff; wnm_in = wnm_ff; wsl_in = wsl_ff;
      t_in = t_ff; enm_in = enm_ff; imark_in = imark_ff;
      idx_in = idx_ff; walk_n_in = walk_n_ff;
      hit_in = hit_ff; taken_in = taken_ff; free_in = free_ff; free_idx_in = free_idx_ff;
      res_st_in = res_st_ff; res_pid_in = res_pid_ff; res_dev_in = res_dev_ff;
      res_arm_in = res_arm_ff; res_run_in = res_run_ff; res_sl_in = res_sl_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;

      case (cmd.op)
         cps_pkg::OP_LOAD: begin
            typ_in     = cps_pkg::req_kind_type'(req_tuser);
            lvl_in     = req_tdata[1:0];
            nop_in     = req_tdata[17:2];
            widx_in    = req_tdata[21:18];
            widl_in    = req_tdata[22];
            wnm_in     = req_tdata[38:23];
            wsl_in     = req_tdata[54:39];
            t_in       = plan_sl_ff[pos_ff];
            enm_in     = plan_nm_ff[pos_ff];
            imark_in   = plan_idl_ff[pos_ff];
            idx_in     = '0;
            walk_n_in  = dev_cnt_ff;
            hit_in     = 1'b0;
            taken_in   = 1'b0;
            free_in    = 1'b0;
            res_pid_in = '0;
            res_dev_in = 1'b0;
            res_arm_in = 1'b0;
            res_run_in = 1'b0;
            res_sl_in  = '0;
            res_st_in  = cps_pkg::RES_OK;
            if (req_tuser == cps_pkg::REQ_CREATE && req_tdata[1:0] == cps_pkg::LVL_INVALID) begin
               res_st_in = cps_pkg::RES_BAD_LVL;
            end
         end
         cps_pkg::OP_DEV_STEP: begin
            dev_ring_in[dev_tail_ff] = e_dev;
            dev_head_in = dev_head_ff + 1'b1;
            dev_tail_in = dev_tail_ff + 1'b1;
            idx_in      = idx_ff + 1'b1;
            if (dev_due) begin
               cur_in            = {1'b0, e_dev} + 5'd1;
               slot_cd_in[e_dev] = slot_per_ff[e_dev];
               res_dev_in        = 1'b1;
            end else begin
               slot_cd_in[e_dev] = (slot_cd_ff[e_dev] > t_ff) ? slot_cd_ff[e_dev] - t_ff : 16'd0;
            end
         end
         cps_pkg::OP_IDLE_PICK: begin
            if (spo_cnt_ff != '0) begin
               cur_in = {1'b0, e_spo} + 5'd1;
               spo_ring_in[spo_tail_ff] = e_spo;
               spo_head_in = spo_head_ff + 1'b1;
               spo_tail_in = spo_tail_ff + 1'b1;
            end else begin
               cur_in = '0;
            end
         end
         cps_pkg::OP_IDX_CLR: idx_in = '0;
         cps_pkg::OP_NAME_STEP: begin
            idx_in = idx_ff + 1'b1;
            if (name_hit) begin
               hit_in = 1'b1;
               cur_in = {1'b0, sidx} + 5'd1;
            end
         end
         cps_pkg::OP_ARM: begin
            res_arm_in = 1'b1;
            res_sl_in  = t_ff;
            nxt_in     = {1'b0, pos_ff} + 1'b1;
            if (!imark_ff && !hit_ff) begin
               res_st_in = cps_pkg::RES_NOTFOUND;
            end
         end
         cps_pkg::OP_MOD_SUB: nxt_in = nxt_ff - used_len[PW:0];
         cps_pkg::OP_POS_SET: pos_in = nxt_ff[PW-1:0];
         cps_pkg::OP_PROMOTE: begin
            res_pid_in = cur_ff;
            if (cur_ff == 5'd0) begin
               res_run_in = 1'b1;
            end else if (slot_st_ff[cur_slot] == cps_pkg::ST_NEW ||
                         slot_st_ff[cur_slot] == cps_pkg::ST_READY) begin
               res_run_in           = 1'b1;
               slot_st_in[cur_slot] = cps_pkg::ST_READY;
            end
         end
         cps_pkg::OP_CRT_STEP: begin
            idx_in = idx_ff + 1'b1;
            if (lvl_ff == cps_pkg::LVL_PERIODIC && name_hit) begin
               taken_in = 1'b1;
            end
            if (slot_st_ff[sidx] == cps_pkg::ST_TERMINATED && !free_ff) begin
               free_in     = 1'b1;
               free_idx_in = sidx;
            end
         end
         cps_pkg::OP_CRT_COMMIT: begin
            if (taken_ff || !free_ff) begin
               res_st_in = cps_pkg::RES_NO_SLOT;
            end else begin
               slot_st_in[free_idx_ff]  = cps_pkg::ST_NEW;
               slot_lvl_in[free_idx_ff] = lvl_ff;
               slot_nv_in[free_idx_ff]  = 1'b0;
               res_pid_in = {1'b0, free_idx_ff} + 5'd1;
               case (lvl_ff)
                  cps_pkg::LVL_SPORADIC: begin
                     if (spo_cnt_ff < CW'(NP)) begin
                        spo_ring_in[spo_tail_ff] = free_idx_ff;
                        spo_tail_in = spo_tail_ff + 1'b1;
                        spo_cnt_in  = spo_cnt_ff + 1'b1;
                     end
                  end
                  cps_pkg::LVL_DEVICE: begin
                     if (dev_cnt_ff < CW'(NP)) begin
                        dev_ring_in[dev_tail_ff] = free_idx_ff;
                        dev_tail_in = dev_tail_ff + 1'b1;
                        dev_cnt_in  = dev_cnt_ff + 1'b1;
                     end
                     slot_per_in[free_idx_ff] = nop_ff;
                     slot_cd_in[free_idx_ff]  = nop_ff;
                  end
                  default: begin
                     slot_name_in[free_idx_ff] = nop_ff;
                     slot_nv_in[free_idx_ff]   = 1'b1;
                  end
               endcase
            end
         end
         cps_pkg::OP_TRM_CLEAR: begin
            slot_st_in[cur_slot]  = cps_pkg::ST_TERMINATED;
            slot_nv_in[cur_slot]  = 1'b0;
            slot_per_in[cur_slot] = '0;
            res_pid_in = cur_ff;
            idx_in     = '0;
            lvl_in     = slot_lvl_ff[cur_slot];
            case (slot_lvl_ff[cur_slot])
               cps_pkg::LVL_SPORADIC: walk_n_in = spo_cnt_ff;
               cps_pkg::LVL_DEVICE:   walk_n_in = dev_cnt_ff;
               default:               walk_n_in = '0;
            endcase
         end
         cps_pkg::OP_TRM_STEP: begin
            idx_in = idx_ff + 1'b1;
            if (lvl_ff == cps_pkg::LVL_SPORADIC) begin
               spo_head_in = spo_head_ff + 1'b1;
               if (trm_e == cur_slot) begin
                  spo_cnt_in = spo_cnt_ff - 1'b1;
               end else begin
                  spo_ring_in[spo_tail_ff] = e_spo;
                  spo_tail_in = spo_tail_ff + 1'b1;
               end
            end else begin
               dev_head_in = dev_head_ff + 1'b1;
               if (trm_e == cur_slot) begin
                  dev_cnt_in = dev_cnt_ff - 1'b1;
               end else begin
                  dev_ring_in[dev_tail_ff] = e_dev;
                  dev_tail_in = dev_tail_ff + 1'b1;
               end
            end
         end
         cps_pkg::OP_PLAN_WR: begin
            plan_idl_in[widx_ff] = widl_ff;
            plan_nm_in[widx_ff]  = wnm_ff;
            plan_sl_in[widx_ff]  = wsl_ff;
         end
         cps_pkg::OP_EMIT: begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = {6'd0, res_run_ff, res_sl_ff, res_arm_ff, res_dev_ff,
                            res_pid_ff, res_st_ff};
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NP; i++) begin
            slot_st_ff[i]   <= cps_pkg::ST_TERMINATED;
            slot_lvl_ff[i]  <= '0;
            slot_name_ff[i] <= '0;
            slot_nv_ff[i]   <= 1'b0;
            slot_per_ff[i]  <= '0;
            slot_cd_ff[i]   <= '0;
         end
         dev_head_ff  <= '0;
         dev_tail_ff  <= '0;
         dev_cnt_ff   <= '0;
         spo_head_ff  <= '0;
         spo_tail_ff  <= '0;
         spo_cnt_ff   <= '0;
         pos_ff       <= '0;
         plen_ff      <= 5'd1;
         cur_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         slot_st_ff   <= slot_st_in;
         slot_lvl_ff  <= slot_lvl_in;
         slot_name_ff <= slot_name_in;
         slot_nv_ff   <= slot_nv_in;
         slot_per_ff  <= slot_per_in;
         slot_cd_ff   <= slot_cd_in;
         dev_head_ff  <= dev_head_in;
         dev_tail_ff  <= dev_tail_in;
         dev_cnt_ff   <= dev_cnt_in;
         spo_head_ff  <= spo_head_in;
         spo_tail_ff  <= spo_tail_in;
         spo_cnt_ff   <= spo_cnt_in;
         pos_ff       <= pos_in;
         plen_ff      <= plen_in;
         cur_ff       <= cur_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      dev_ring_ff <= dev_ring_in;
      spo_ring_ff <= spo_ring_in;
      plan_nm_ff  <= plan_nm_in;
      plan_idl_ff <= plan_idl_in;
      plan_sl_ff  <= plan_sl_in;
      nxt_ff      <= nxt_in;
      typ_ff      <= typ_in;
      lvl_ff      <= lvl_in;
      nop_ff      <= nop_in;
      widx_ff     <= widx_in;
      widl_ff     <= widl_in;
      wnm_ff      <= wnm_in;
      wsl_ff      <= wsl_in;
      t_ff        <= t_in;
      enm_ff      <= enm_in;
      imark_ff    <= imark_in;
      idx_ff      <= idx_in;
      walk_n_ff   <= walk_n_in;
      hit_ff      <= hit_in;
      taken_ff    <= taken_in;
      free_ff     <= free_in;
      free_idx_ff <= free_idx_in;
      res_st_ff   <= res_st_in;
      res_pid_ff  <= res_pid_in;
      res_dev_ff  <= res_dev_in;
      res_arm_ff  <= res_arm_in;
      res_run_ff  <= res_run_in;
      res_sl_ff   <= res_sl_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_dev_cnt: assert property (@(posedge clock) disable iff (reset)
      dev_cnt_ff <= CW'(NP)) else $error("device ring count overflow");
   a_spo_cnt: assert property (@(posedge clock) disable iff (reset)
      spo_cnt_ff <= CW'(NP)) else $error("sporadic ring count overflow");
   a_cur_rng: assert property (@(posedge clock) disable iff (reset)
      cur_ff <= 5'(NP)) else $error("current pid out of range");
   a_emit: assert property (@(posedge clock) disable iff (reset)
      cmd.op == cps_pkg::OP_EMIT |=> rsp_valid_ff) else $error("result lost on emit");
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.op == cps_pkg::OP_EMIT |-> !(rsp_valid_ff && !rsp_tready))
      else $error("result overwritten");

endmodule

[hdl/cyclic_plan_process_scheduler.sv]
// Process selector with a 16-slot table, device and sporadic ring queues and a
// cyclic plan of up to 16 entries. Request kinds in req_tuser: schedule, create,
// terminate current, write plan entry; one response per request. One request is
// in flight at a time; a new one is taken while the previous response still waits.
// The sequencer steps one slot or one ring entry per cycle. Plan write, bad-level
// create and idle terminate go straight to done; create scans every slot; terminate
// walks the ring queue of the current process until it finds its entry; schedule
// walks the device ring until a device is due, else takes a sporadic process for an
// idle plan entry or runs a name search, then wraps the plan position by subtract steps.
// A response held off by rsp_tready stalls the next request once it reaches done.
module cyclic_plan_process_scheduler (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [1:0]  req_tuser,   // req_type
   // proc_level, name_or_period, plan_index, plan_is_idle, plan_name, plan_slice_ms
   input  logic [55:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // status, pid, from_device, preempt_armed, slice_ms, runnable
   output logic [31:0] rsp_tdata,
   input  logic        csr_wen,
   input  logic [4:0]  csr_wdata    // plan_length
);

   cps_pkg::cmd_type  cmd;
   cps_pkg::stat_type stat;

   cps_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   cps_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata),
      .cmd        (cmd),
      .stat       (stat)
   );

endmodule
